// ----- rtl/line_follow_steering_macros.svh -----
// assertion macros for the line follower steering block
// needs clk and rst in the scope where a macro is used
`ifndef LINE_FOLLOW_STEERING_MACROS_SVH
`define LINE_FOLLOW_STEERING_MACROS_SVH

// implication checked on every clock outside reset
`define LFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that holds on every clock outside reset
`define LFS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ----- rtl/lfs_pkg.sv -----
// shared types and constants for the line follower steering block
// no dependencies
package lfs_pkg;

  localparam int SpeedW = 7;
  localparam int DriveW = 8;
  localparam int ModeW  = 2;
  localparam int GradeW = 3;

  localparam logic [SpeedW-1:0] SPEED_RESET = 7'd30;
  localparam logic [SpeedW-1:0] SPEED_MIN   = 7'd10;
  localparam logic [SpeedW-1:0] SPEED_MAX   = 7'd80;

  localparam logic [ModeW-1:0] MODE_SEARCHING = 2'd0;
  localparam logic [ModeW-1:0] MODE_CENTRED   = 2'd1;
  localparam logic [ModeW-1:0] MODE_TRACKING  = 2'd2;

  // register index of base_speed
  localparam logic REG_BASE_SPEED = 1'b0;

  typedef logic signed [DriveW-1:0] drive_t;
  typedef logic signed [GradeW-1:0] grade_t;

  typedef struct packed {
    logic [ModeW-1:0] track_mode;
    drive_t           right_drive;
    drive_t           left_drive;
  } lfs_result_t;

  // speed offset for a turn grade magnitude
  function automatic drive_t grade_delta(input logic [1:0] mag);
    drive_t d;
    case (mag)
      2'd1:    d = 8'sd5;
      2'd2:    d = 8'sd8;
      2'd3:    d = 8'sd10;
      default: d = 8'sd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/lfs_cfg.sv -----
// configuration register file: base speed with write clamping
// depends on lfs_pkg
module lfs_cfg
  import lfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [SpeedW-1:0] base_speed
);

  logic              wr_en;
  logic [SpeedW-1:0] wr_value;
  logic [SpeedW-1:0] base_speed_next;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready && (paddr[2] == REG_BASE_SPEED);
  assign wr_value = pwdata[SpeedW-1:0];

  always_comb begin
    if (wr_value < SPEED_MIN) begin
      base_speed_next = SPEED_MIN;
    end else if (wr_value > SPEED_MAX) begin
      base_speed_next = SPEED_MAX;
    end else begin
      base_speed_next = wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed <= SPEED_RESET;
    end else if (wr_en) begin
      base_speed <= base_speed_next;
    end
  end

  assign prdata = (paddr[2] == REG_BASE_SPEED) ? {{(32-SpeedW){1'b0}}, base_speed} : 32'd0;

endmodule

// ----- rtl/lfs_core.sv -----
// sensor register, pattern match, drive calculation and result register
// depends on lfs_pkg
module lfs_core
  import lfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SpeedW-1:0] base_speed,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        sensor_bits,
  output logic              res_valid,
  input  logic              res_ready,
  output lfs_result_t       result
);

  logic        stg_valid;
  logic [7:0]  stg_bits;
  logic        advance;
  logic [7:0]  pattern;
  logic        matched;
  grade_t      grade;
  grade_t      last_grade;
  grade_t      grade_next;
  logic [1:0]  mag;
  drive_t      delta;
  drive_t      speed;
  lfs_result_t result_next;

  assign advance  = !res_valid || res_ready;
  assign in_ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_bits <= sensor_bits;
    end
  end

  // sensor polarity inverted: 0 marks black
  assign pattern = ~stg_bits;

  always_comb begin
    matched = 1'b1;
    grade   = 3'sd0;
    unique case (pattern) inside
      8'hEF, 8'hE7, 8'hF7: grade = 3'sd0;
      8'hF3, 8'hFB:        grade = 3'sd1;
      8'hF9, 8'hFD:        grade = 3'sd2;
      8'hFC, 8'hFE:        grade = 3'sd3;
      8'hCF, 8'hDF:        grade = -3'sd1;
      8'h9F, 8'hBF:        grade = -3'sd2;
      8'h3F, 8'h7F:        grade = -3'sd3;
      default:             matched = 1'b0;
    endcase
  end

  assign mag   = grade[GradeW-1] ? 2'(-grade) : grade[1:0];
  assign delta = grade_delta(mag);
  assign speed = drive_t'({1'b0, base_speed});

  always_comb begin
    grade_next  = last_grade;
    result_next = '0;
    if (matched) begin
      grade_next = grade;
      if (grade == 3'sd0) begin
        result_next.left_drive  = speed;
        result_next.right_drive = speed;
        result_next.track_mode  = MODE_CENTRED;
      end else if (!grade[GradeW-1]) begin
        result_next.left_drive  = speed + delta;
        result_next.right_drive = speed - delta;
        result_next.track_mode  = MODE_TRACKING;
      end else begin
        result_next.left_drive  = speed - delta;
        result_next.right_drive = speed + delta;
        result_next.track_mode  = MODE_TRACKING;
      end
    end else begin
      // lost the line: harder turn towards the last side seen
      result_next.track_mode = MODE_SEARCHING;
      case (last_grade)
        3'sd3: begin
          result_next.left_drive  = speed + 8'sd10;
          result_next.right_drive = -8'sd10;
        end
        3'sd2: begin
          result_next.left_drive  = speed + 8'sd8;
          result_next.right_drive = -8'sd5;
        end
        3'sd1: begin
          result_next.left_drive  = speed + 8'sd5;
          result_next.right_drive = 8'sd0;
        end
        -3'sd1: begin
          result_next.left_drive  = 8'sd0;
          result_next.right_drive = speed + 8'sd5;
        end
        -3'sd2: begin
          result_next.left_drive  = -8'sd5;
          result_next.right_drive = speed + 8'sd8;
        end
        -3'sd3: begin
          result_next.left_drive  = -8'sd10;
          result_next.right_drive = speed + 8'sd10;
        end
        default: begin
          result_next.left_drive  = speed;
          result_next.right_drive = speed;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      last_grade <= 3'sd0;
    end else if (advance) begin
      res_valid <= stg_valid;
      if (stg_valid) begin
        last_grade <= grade_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stg_valid) begin
      result <= result_next;
    end
  end

endmodule

// ----- rtl/line_follow_steering.sv -----
// line follower steering block: sensor word in, motor drive word out
// depends on lfs_pkg, lfs_cfg, lfs_core and line_follow_steering_macros.svh
//
// usage
//   slave stream: one word per raw gray sensor byte (1 = black under sensor)
//   master stream: one word per sensor word, carrying left and right motor
//   commands (signed) and the tracking mode (searching, centred, tracking)
//   apb port: base_speed at byte address 0, writes clamped into 10..80
// timing
//   path: an accepted word moves from the sensor register through the pattern match
//   into the result register, and m_tvalid rises once the word is in the result register
//   throughput is one word per cycle while m_tready is high; the sensor register and the result
//   register form a two-entry pipeline, so a new word is taken while a
//   finished result still waits on the master side
// reset
//   both pipeline stages empty, base_speed back to 30, remembered turn
//   grade back to straight ahead
// stall
//   when m_tready is low the result holds; the sensor stage still takes one
//   more word, then s_tready drops until the result is taken
module line_follow_steering
  import lfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sensor_bits
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] left_drive, [15:8] right_drive, [17:16] track_mode
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "line_follow_steering_macros.svh"

  logic [SpeedW-1:0] base_speed;
  lfs_result_t       result;

  // register file
  lfs_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .base_speed (base_speed)
  );

  // steering datapath
  lfs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .base_speed  (base_speed),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sensor_bits (s_tdata),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .result      (result)
  );

  // pack the result word, left drive in the lowest byte
  assign m_tdata = {6'd0, result.track_mode, result.right_drive, result.left_drive};

  // clamped speed never leaves its range
  `LFS_ASSERT_ALWAYS(a_speed_range, (base_speed >= SPEED_MIN) && (base_speed <= SPEED_MAX), "base speed out of range")

  // centred output drives both motors alike
  `LFS_ASSERT_IMP(a_centred_even, m_tvalid && (result.track_mode == MODE_CENTRED), result.left_drive == result.right_drive, "centred result with unequal drive")

  // tracking output always turns
  `LFS_ASSERT_IMP(a_tracking_turns, m_tvalid && (result.track_mode == MODE_TRACKING), result.left_drive != result.right_drive, "tracking result without a turn")

endmodule

// ----- tb/sv/tb_line_follow_steering.sv -----
// self-checking testbench for the line follower steering block
// depends on lfs_pkg and the line_follow_steering rtl, nothing else
`timescale 1ns / 1ps

module tb_line_follow_steering
  import lfs_pkg::*;
();

  localparam int WatchdogLimit = 2000;
  // second register slot, nothing decoded behind it
  localparam int RegSpare = 1;
  localparam logic [2:0] AddrSpeed = 3'(4 * int'(REG_BASE_SPEED));
  localparam logic [2:0] AddrSpare = 3'(4 * RegSpare);

  // inverted sensor patterns: three centred, then +1 +2 +3 -1 -2 -3 pairs
  localparam logic [7:0] LinePat [15] = '{
    8'hEF, 8'hE7, 8'hF7,
    8'hF3, 8'hFB, 8'hF9, 8'hFD, 8'hFC, 8'hFE,
    8'hCF, 8'hDF, 8'h9F, 8'hBF, 8'h3F, 8'h7F
  };
  localparam int TurnOffset [4] = '{0, 5, 8, 10};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state, mirrors the block
  logic [SpeedW-1:0] speed_setting = SPEED_RESET;
  grade_t            held_grade = '0;

  lfs_result_t expected_drive [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int words_checked  = 0;
  int speed_writes   = 0;
  int quiet_cycles   = 0;

  line_follow_steering dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // steering prediction for one raw sensor byte; updates the held grade
  function automatic lfs_result_t predict_steering(input logic [7:0] raw);
    logic [7:0]  pat;
    int          s;
    int          g;
    int          left;
    int          right;
    bit          hit;
    lfs_result_t r;
    pat = ~raw;
    s   = int'(speed_setting);
    hit = 1'b1;
    g   = 0;
    case (pat)
      8'hEF, 8'hE7, 8'hF7: g = 0;
      8'hF3, 8'hFB:        g = 1;
      8'hF9, 8'hFD:        g = 2;
      8'hFC, 8'hFE:        g = 3;
      8'hCF, 8'hDF:        g = -1;
      8'h9F, 8'hBF:        g = -2;
      8'h3F, 8'h7F:        g = -3;
      default:             hit = 1'b0;
    endcase
    if (hit) begin
      if (g >= 0) begin
        left  = s + TurnOffset[g];
        right = s - TurnOffset[g];
      end else begin
        left  = s - TurnOffset[-g];
        right = s + TurnOffset[-g];
      end
      held_grade   = grade_t'(g);
      r.track_mode = (g == 0) ? MODE_CENTRED : MODE_TRACKING;
    end else begin
      // line lost: hard recovery turn towards the side last seen
      r.track_mode = MODE_SEARCHING;
      case (int'(held_grade))
        3:       begin left = s + 10; right = -10;    end
        2:       begin left = s + 8;  right = -5;     end
        1:       begin left = s + 5;  right = 0;      end
        -1:      begin left = 0;      right = s + 5;  end
        -2:      begin left = -5;     right = s + 8;  end
        -3:      begin left = -10;    right = s + 10; end
        default: begin left = s;      right = s;      end
      endcase
    end
    r.left_drive  = left[7:0];
    r.right_drive = right[7:0];
    return r;
  endfunction

  // one sensor word; drive stays up for a back-to-back follow-on word
  task automatic send_sensor(input logic [7:0] raw);
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
    expected_drive.push_back(predict_steering(raw));
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // mostly real line patterns, the rest arbitrary bytes
  task automatic send_random(input int count);
    repeat (count) begin
      if ($urandom_range(99) < 65) send_sensor(~LinePat[$urandom_range(14)]);
      else send_sensor(8'($urandom_range(255)));
    end
  endtask

  // stop sending and let every outstanding word come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    logic [6:0] v;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    speed_writes++;
    if (addr == AddrSpeed) begin
      v = data[6:0];
      if (v < SPEED_MIN) v = SPEED_MIN;
      else if (v > SPEED_MAX) v = SPEED_MAX;
      speed_setting = v;
    end
    // leave the bus idle before the next access
    @(posedge clk);
  endtask

  task automatic check_speed_readback;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= AddrSpeed;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {25'd0, speed_setting}) begin
      $error("base_speed readback: expected %0d, actual %0d", speed_setting, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker: each word against the oldest prediction
  always @(posedge clk) begin
    lfs_result_t want;
    lfs_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[17:0];
      words_checked++;
      if (expected_drive.size() == 0) begin
        $error("drive word with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_drive.pop_front();
        if (got.left_drive !== want.left_drive) begin
          $error("left_drive: expected %0d, actual %0d", want.left_drive, got.left_drive);
          fail_count++;
        end
        if (got.right_drive !== want.right_drive) begin
          $error("right_drive: expected %0d, actual %0d", want.right_drive, got.right_drive);
          fail_count++;
        end
        if (got.track_mode !== want.track_mode) begin
          $error("track_mode: expected %0d, actual %0d", want.track_mode, got.track_mode);
          fail_count++;
        end
        if (m_tdata[23:18] !== '0) begin
          $error("tdata padding: expected 0, actual %h", m_tdata[23:18]);
          fail_count++;
        end
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no word or register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no handshake for %0d cycles", WatchdogLimit);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset value of the speed, then every pattern and a lost line after each grade
  task automatic test_reset_patterns;
    check_speed_readback();
    send_sensor(8'h00);                // all white, nothing remembered yet
    for (int k = 0; k < 6; k++) begin
      send_sensor(~LinePat[3 + 2*k]);
      send_sensor(k[0] ? 8'hFF : 8'h00);
      send_sensor(~LinePat[4 + 2*k]);
    end
    for (int k = 0; k < 3; k++) send_sensor(~LinePat[k]);
    send_sensor(8'hFF);                // lost line after centred
    drain();
  endtask

  // clamping at both ends, ignored upper bits and the undecoded slot
  task automatic test_speed_clamp;
    logic [31:0] writes [7];
    writes = '{32'd0, 32'd9, 32'd10, 32'd80, 32'd81, 32'd127, 32'hFFFF_FFAD};
    foreach (writes[i]) begin
      apb_write(AddrSpeed, writes[i]);
      check_speed_readback();
      send_random(12);
      drain();
    end
    apb_write(AddrSpare, 32'd12);
    check_speed_readback();
    send_random(12);
    drain();
  endtask

  // long random runs, one speed and one idling profile per phase
  task automatic test_random_traffic;
    logic [31:0] speeds [4];
    int          send_pcts [4];
    int          recv_pcts [4];
    speeds    = '{32'd10, 32'd80, 32'd55, 32'h0000_0180};
    send_pcts = '{0, 65, 0, 27};
    recv_pcts = '{0, 0, 65, 27};
    foreach (speeds[i]) begin
      apb_write(AddrSpeed, speeds[i]);
      send_idle_pct  = send_pcts[i];
      recv_stall_pct = recv_pcts[i];
      send_random(375);
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_patterns();
    test_speed_clamp();
    test_random_traffic();
    repeat (10) @(posedge clk);
    $display("%0d drive words checked across four idling profiles", words_checked);
    $display("%0d register writes, speed clamped at both ends", speed_writes);
    if (fail_count == 0 && expected_drive.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lfs_pkg.sv
rtl/lfs_cfg.sv
rtl/lfs_core.sv
rtl/line_follow_steering.sv
tb/sv/tb_line_follow_steering.sv
